FILE: rtl/mrf_pkg.sv
// Shared types, codes and constants for the mesh rebroadcast filter.
// No dependencies; imported by mrf_hop_rewrite, mesh_rebroadcast_filter and the testbench.
package mrf_pkg;

  localparam int TRACK_DEPTH_DEF = 16;
  localparam int NUM_CLASSES     = 4;
  localparam int CLS_W           = 2;

  localparam logic [2:0] MAX_HOPS        = 3'd7;
  localparam logic [2:0] LATE_TELEM_HOPS = 3'd2;

  // node roles; codes above ROLE_OTHER behave as a plain client
  localparam logic [2:0] ROLE_CLIENT      = 3'd0;
  localparam logic [2:0] ROLE_CLIENT_MUTE = 3'd1;
  localparam logic [2:0] ROLE_ROUTER      = 3'd2;
  localparam logic [2:0] ROLE_ROUTER_LATE = 3'd3;
  localparam logic [2:0] ROLE_REPEATER    = 3'd4;
  localparam logic [2:0] ROLE_OTHER       = 3'd5;

  // packet classes
  localparam logic [2:0] CLS_ENCRYPTED = 3'd0;
  localparam logic [2:0] CLS_TELEMETRY = 3'd1;
  localparam logic [2:0] CLS_POSITION  = 3'd2;
  localparam logic [2:0] CLS_NODEINFO  = 3'd3;
  localparam logic [2:0] CLS_DECODED   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_NODE_ROLE     = 2'd0;
  localparam logic [1:0] REG_REBCAST_EN    = 2'd1;
  localparam logic [1:0] REG_ENC_TIMEOUT   = 2'd2;
  localparam logic [1:0] REG_DEC_TIMEOUT   = 2'd3;

  localparam logic [31:0] ENC_TIMEOUT_RST = 32'd600000;
  localparam logic [31:0] DEC_TIMEOUT_RST = 32'd300000;

  typedef enum logic [2:0] {
    V_FORWARDED  = 3'd0,
    V_BLOCKED    = 3'd1,
    V_INELIGIBLE = 3'd2,
    V_ZERO_ID    = 3'd3,
    V_NOT_REBC   = 3'd4,
    V_RATE_LIM   = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // hop rewrite request: role summary and the captured hop fields
  typedef struct packed {
    logic       router;
    logic       late;
    logic [2:0] cls;
    logic [2:0] hops_left;
    logic [2:0] hops_origin;
  } hop_ctl_t;

  typedef struct packed {
    logic [2:0] hops_left;
    logic [2:0] hops_origin;
  } hop_res_t;

endpackage

FILE: rtl/mesh_rebroadcast_filter.sv
// A word that needs a per-source table check scans its class table through the
// single read port of the source/time memory and stops early on a hit; any other
// word goes straight to the done state. No new word is taken until the result of
// the last one has been loaded into the output register.
// Reset clears valid bits, insert pointers, configuration and control registers;
// the captured word, memory read data and output data are not reset.
module mesh_rebroadcast_filter #(
  parameter int TRACK_DEPTH = mrf_pkg::TRACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_ms[31:0], source_node[63:32], hops_left[66:64], hops_origin[69:67],
  // addressed_to_us[70], sent_by_us[71], id_is_zero[72], source_blocked[73],
  // has_flag_word[74], mqtt_ok_in[75], zero fill[79:76]
  input  logic [79:0] s_tdata,
  // packet_class[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // forward[0], verdict[3:1], new_hops_left[6:4], new_hops_origin[9:7],
  // mqtt_ok_out[10], zero fill[15:11]
  output logic [15:0] m_tdata
);
  import mrf_pkg::*;

  localparam int IW    = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
  localparam int AW    = CLS_W + IW;
  localparam int MEM_N = NUM_CLASSES << IW;

  // configuration
  logic [2:0]  node_role;
  logic        rebcast_en;
  logic [31:0] enc_timeout;
  logic [31:0] dec_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_role   <= ROLE_CLIENT;
      rebcast_en  <= 1'b1;
      enc_timeout <= ENC_TIMEOUT_RST;
      dec_timeout <= DEC_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODE_ROLE:   node_role   <= cfg_data[2:0];
        REG_REBCAST_EN:  rebcast_en  <= cfg_data[0];
        REG_ENC_TIMEOUT: enc_timeout <= cfg_data;
        REG_DEC_TIMEOUT: dec_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  logic is_router;
  assign is_router = (node_role == ROLE_ROUTER) || (node_role == ROLE_ROUTER_LATE) ||
                     (node_role == ROLE_REPEATER);

  // incoming word fields
  logic [31:0] in_now;
  logic [31:0] in_src;
  logic [2:0]  in_cls;
  logic [2:0]  in_hl;
  logic [2:0]  in_hs;
  logic        in_to_us, in_from_us, in_id_zero, in_blocked, in_flag, in_mqtt;

  assign in_now     = s_tdata[31:0];
  assign in_src     = s_tdata[63:32];
  assign in_hl      = s_tdata[66:64];
  assign in_hs      = s_tdata[69:67];
  assign in_to_us   = s_tdata[70];
  assign in_from_us = s_tdata[71];
  assign in_id_zero = s_tdata[72];
  assign in_blocked = s_tdata[73];
  assign in_flag    = s_tdata[74];
  assign in_mqtt    = s_tdata[75];
  // classes beyond node info all act as other decoded
  assign in_cls     = (s_tuser > CLS_DECODED) ? CLS_DECODED : s_tuser;

  verdict_t early_v;
  logic     needs_scan;

  always_comb begin
    if (in_blocked) begin
      early_v = V_BLOCKED;
    end else if (in_to_us || in_hl == 3'd0 || in_from_us) begin
      early_v = V_INELIGIBLE;
    end else if (in_id_zero) begin
      early_v = V_ZERO_ID;
    end else if (node_role == ROLE_CLIENT_MUTE || !rebcast_en) begin
      early_v = V_NOT_REBC;
    end else begin
      early_v = V_FORWARDED;
    end
  end

  assign needs_scan = (early_v == V_FORWARDED) && is_router && !in_cls[2];

  // captured word
  logic [31:0] now_q;
  logic [31:0] src_q;
  logic [2:0]  cls_q;
  logic [2:0]  hl_q;
  logic [2:0]  hs_q;
  logic        mqtt_q;
  verdict_t    res_verdict;
  verdict_t    res_next;

  // control
  state_t        state;
  state_t        state_next;
  logic [IW:0]   rd_cnt;
  logic          cmp_vld;
  logic [IW-1:0] cmp_idx;
  logic [IW-1:0] ins_ptr [NUM_CLASSES];
  logic [MEM_N-1:0] entry_valid;

  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  logic [63:0]   rd_data;
  logic          set_valid;
  logic          load_out;
  logic          issue;
  logic          hit;
  logic          too_recent;
  logic          last_cmp;
  logic [31:0]   timeout;
  logic [31:0]   age;
  logic [CLS_W-1:0] cls2;
  logic [AW-1:0] cmp_addr;

  assign cls2       = cls_q[CLS_W-1:0];
  assign cmp_addr   = {cls2, cmp_idx};
  assign mem_ra     = {cls2, rd_cnt[IW-1:0]};
  assign issue      = rd_cnt < (IW+1)'(TRACK_DEPTH);
  assign timeout    = (cls_q == CLS_ENCRYPTED) ? enc_timeout : dec_timeout;
  assign age        = now_q - rd_data[31:0];
  assign hit        = cmp_vld && entry_valid[cmp_addr] && (rd_data[63:32] == src_q);
  assign too_recent = age < timeout;
  assign last_cmp   = cmp_vld && (cmp_idx == IW'(TRACK_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = cmp_addr;
    set_valid  = 1'b0;
    load_out   = 1'b0;
    res_next   = res_verdict;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = needs_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        mem_re = issue;
        if (hit) begin
          // known source: drop if too recent, else refresh its time
          if (too_recent) begin
            res_next = V_RATE_LIM;
          end else begin
            mem_we = 1'b1;
          end
          state_next = ST_DONE;
        end else if (last_cmp) begin
          mem_we     = 1'b1;
          mem_wa     = {cls2, ins_ptr[cls2]};
          set_valid  = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      now_q       <= in_now;
      src_q       <= in_src;
      cls_q       <= in_cls;
      hl_q        <= in_hl;
      hs_q        <= in_hs;
      mqtt_q      <= in_mqtt | in_flag;
      res_verdict <= early_v;
    end else begin
      res_verdict <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt  <= '0;
      cmp_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      rd_cnt  <= '0;
      cmp_vld <= 1'b0;
    end else if (state == ST_SCAN) begin
      cmp_vld <= issue;
      if (issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
    end else begin
      cmp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_cnt[IW-1:0];
  end

  // valid bits and round-robin insert pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        ins_ptr[c] <= '0;
      end
    end else if (set_valid) begin
      entry_valid[mem_wa] <= 1'b1;
      ins_ptr[cls2] <= (ins_ptr[cls2] == IW'(TRACK_DEPTH - 1)) ? '0
                                                               : ins_ptr[cls2] + 1'b1;
    end
  end

  // source/time memory: {source, time} per entry
  logic [63:0] track_mem [MEM_N];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      track_mem[mem_wa] <= {src_q, now_q};
    end
    if (mem_re) begin
      rd_data <= track_mem[mem_ra];
    end
  end

  // hop rewrite for the forwarded copy
  hop_ctl_t hop_ctl;
  hop_res_t hop_res;

  assign hop_ctl.router      = is_router;
  assign hop_ctl.late        = (node_role == ROLE_ROUTER_LATE);
  assign hop_ctl.cls         = cls_q;
  assign hop_ctl.hops_left   = hl_q;
  assign hop_ctl.hops_origin = hs_q;

  mrf_hop_rewrite u_hop (
    .ctl(hop_ctl),
    .res(hop_res)
  );

  logic fwd;
  assign fwd = (res_verdict == V_FORWARDED);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {5'd0,
                  fwd & mqtt_q,
                  fwd ? hop_res.hops_origin : 3'd0,
                  fwd ? hop_res.hops_left : 3'd0,
                  res_verdict,
                  fwd};
    end
  end

`ifndef SYNTHESIS
  a_we_in_scan: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_SCAN)
    else $error("table write outside a scan");

  a_ins_valid: assert property (@(posedge clk) disable iff (rst)
    set_valid |=> entry_valid[$past(mem_wa)])
    else $error("inserted entry not marked valid");

  a_rate_router: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:1] == V_RATE_LIM |-> is_router)
    else $error("rate-limited verdict without a router role");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[10:4] == 7'd0)
    else $error("dropped word carries hop or mqtt fields");
`endif

endmodule

FILE: rtl/mrf_hop_rewrite.sv
// Hop limit / hop start rewrite for a forwarded copy.
// Depends on mrf_pkg (hop_ctl_t, hop_res_t, class codes).
module mrf_hop_rewrite (
  input  mrf_pkg::hop_ctl_t ctl,
  output mrf_pkg::hop_res_t res
);
  import mrf_pkg::*;

  always_comb begin
    res.hops_left   = ctl.hops_left;
    res.hops_origin = ctl.hops_origin;
    if (!ctl.router) begin
      res.hops_left = ctl.hops_left - 3'd1;
    end else if (ctl.cls == CLS_ENCRYPTED || ctl.cls == CLS_POSITION) begin
      res.hops_left = ctl.hops_left - 3'd1;
    end else if (ctl.cls == CLS_TELEMETRY) begin
      if (ctl.late) begin
        res.hops_left = (ctl.hops_left > LATE_TELEM_HOPS) ? LATE_TELEM_HOPS
                                                          : ctl.hops_left - 3'd1;
      end
    end else begin
      // other classes: widen the hop start, or trim a full hop limit
      if (ctl.hops_origin < MAX_HOPS) begin
        res.hops_origin = ctl.hops_origin + 3'd1;
      end else if (ctl.hops_left == MAX_HOPS) begin
        res.hops_left = ctl.hops_left - 3'd1;
      end
    end
  end

endmodule

FILE: tb/tb_mesh_rebroadcast_filter.sv
`timescale 1ns / 100ps
// Self-checking testbench for mesh_rebroadcast_filter: directed and random packet
// headers against an in-line predictor of verdicts, hop rewrites and source tables.
// Depends on rtl/mrf_pkg.sv, rtl/mrf_hop_rewrite.sv and rtl/mesh_rebroadcast_filter.sv.
module tb_mesh_rebroadcast_filter;
  import mrf_pkg::*;

  localparam int TRACK_DEPTH    = TRACK_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int POOL_SIZE      = 20;

  // codes beyond the named ones; all three behave as their fallback
  localparam logic [2:0] ROLE_SPARE_6 = 3'd6;
  localparam logic [2:0] ROLE_SPARE_7 = 3'd7;
  localparam logic [2:0] CLS_SPARE_7  = 3'd7;

  // layout of s_tdata below cls; cls itself travels on s_tuser
  typedef struct packed {
    logic [2:0]  cls;
    logic        mqtt_in;
    logic        has_flag;
    logic        blocked;
    logic        id_zero;
    logic        from_us;
    logic        to_us;
    logic [2:0]  hops_origin;
    logic [2:0]  hops_left;
    logic [31:0] source;
    logic [31:0] now;
  } rx_hdr_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_NODE_ROLE;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // predictor state: configuration copy and per-class source tables
  logic [2:0]  cur_role = ROLE_CLIENT;
  logic        cur_rebcast = 1'b1;
  logic [31:0] cur_enc_timeout = ENC_TIMEOUT_RST;
  logic [31:0] cur_dec_timeout = DEC_TIMEOUT_RST;
  logic [31:0] seen_src   [NUM_CLASSES][TRACK_DEPTH];
  logic [31:0] seen_time  [NUM_CLASSES][TRACK_DEPTH];
  logic        seen_valid [NUM_CLASSES][TRACK_DEPTH] = '{default: 1'b0};
  int          fill_ptr   [NUM_CLASSES] = '{default: 0};

  logic [15:0] pending_verdicts[$];
  logic [15:0] rx_want;
  int          mismatches = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_draw;
  int unsigned idle_cycles = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  logic [31:0] clock_ms = '0;
  logic [31:0] src_pool [POOL_SIZE];

  mesh_rebroadcast_filter #(.TRACK_DEPTH(TRACK_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Look the source up in its class table; refresh or insert unless too recent.
  function automatic logic too_recent(int cls, logic [31:0] src, logic [31:0] now);
    logic [31:0] window;
    logic [31:0] age;
    int i;
    int slot;
    window = (cls == CLS_ENCRYPTED) ? cur_enc_timeout : cur_dec_timeout;
    for (i = 0; i < TRACK_DEPTH; i++) begin
      if (seen_valid[cls][i] && seen_src[cls][i] == src) begin
        age = now - seen_time[cls][i];
        if (age < window) return 1'b1;
        seen_time[cls][i] = now;
        return 1'b0;
      end
    end
    slot = fill_ptr[cls];
    seen_src[cls][slot]   = src;
    seen_time[cls][slot]  = now;
    seen_valid[cls][slot] = 1'b1;
    fill_ptr[cls] = (slot + 1) % TRACK_DEPTH;
    return 1'b0;
  endfunction

  // Work out the result word that one accepted header must produce.
  function automatic logic [15:0] judge_packet(rx_hdr_t h);
    logic [2:0] cls;
    logic [2:0] hl;
    logic [2:0] hs;
    logic       is_router;
    verdict_t   v;
    cls = (h.cls > CLS_DECODED) ? CLS_DECODED : h.cls;
    hl  = h.hops_left;
    hs  = h.hops_origin;
    is_router = (cur_role == ROLE_ROUTER || cur_role == ROLE_ROUTER_LATE ||
                 cur_role == ROLE_REPEATER);
    if (h.blocked) v = V_BLOCKED;
    else if (h.to_us || hl == 3'd0 || h.from_us) v = V_INELIGIBLE;
    else if (h.id_zero) v = V_ZERO_ID;
    else if (cur_role == ROLE_CLIENT_MUTE || !cur_rebcast) v = V_NOT_REBC;
    else v = V_FORWARDED;
    if (v == V_FORWARDED && is_router && cls < NUM_CLASSES) begin
      if (too_recent(int'(cls), h.source, h.now)) v = V_RATE_LIM;
    end
    if (v != V_FORWARDED) return {12'd0, v, 1'b0};

    if (!is_router || cls == CLS_ENCRYPTED || cls == CLS_POSITION) begin
      hl = hl - 3'd1;
    end else if (cls == CLS_TELEMETRY) begin
      if (cur_role == ROLE_ROUTER_LATE) hl = (hl > LATE_TELEM_HOPS) ? LATE_TELEM_HOPS : hl - 3'd1;
    end else if (hs < MAX_HOPS) begin
      hs = hs + 3'd1;
    end else if (hl == MAX_HOPS) begin
      hl = hl - 3'd1;
    end
    return {5'd0, h.mqtt_in | h.has_flag, hs, hl, V_FORWARDED, 1'b1};
  endfunction

  task automatic check_field(string name, logic [4:0] want, logic [4:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // Result side: compare each word, then draw the stall before the next one.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
    end else if (m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: expected no word, got %h", $time, m_tdata);
      end else begin
        rx_want = pending_verdicts.pop_front();
        check_field("forward", 5'(rx_want[0]), 5'(m_tdata[0]));
        check_field("verdict", 5'(rx_want[3:1]), 5'(m_tdata[3:1]));
        check_field("new_hops_left", 5'(rx_want[6:4]), 5'(m_tdata[6:4]));
        check_field("new_hops_origin", 5'(rx_want[9:7]), 5'(m_tdata[9:7]));
        check_field("mqtt_ok_out", 5'(rx_want[10]), 5'(m_tdata[10]));
        check_field("zero fill", rx_want[15:11], m_tdata[15:11]);
      end
      rx_draw = rx_stalls ? $urandom_range(0, 4) : 0;
      rx_hold  <= rx_draw;
      m_tready <= (rx_draw == 0);
    end else if (rx_hold != 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= (rx_hold == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[mesh_rebroadcast_filter] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Leave valid high on acceptance so a back-to-back word needs no extra edge.
  task automatic send_packet(rx_hdr_t h);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, h[75:0]};
    s_tuser  <= h.cls;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_verdicts.push_back(judge_packet(h));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NODE_ROLE:   cur_role = data[2:0];
      REG_REBCAST_EN:  cur_rebcast = data[0];
      REG_ENC_TIMEOUT: cur_enc_timeout = data;
      REG_DEC_TIMEOUT: cur_dec_timeout = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [2:0] role, logic en, logic [31:0] enc, logic [31:0] dec);
    wait_drained();
    write_reg(REG_NODE_ROLE, {29'd0, role});
    write_reg(REG_REBCAST_EN, {31'd0, en});
    write_reg(REG_ENC_TIMEOUT, enc);
    write_reg(REG_DEC_TIMEOUT, dec);
  endtask

  function automatic rx_hdr_t base_hdr(logic [2:0] cls, logic [2:0] hl, logic [2:0] hs,
                                       logic [31:0] src, logic [31:0] now);
    rx_hdr_t h;
    h = '0;
    h.cls         = cls;
    h.hops_left   = hl;
    h.hops_origin = hs;
    h.source      = src;
    h.now         = now;
    return h;
  endfunction

  // Mostly eligible headers from a small source pool so the tables fill, hit and evict.
  function automatic rx_hdr_t random_hdr();
    rx_hdr_t h;
    case ($urandom_range(0, 31))
      0:       clock_ms = $urandom;
      1:       clock_ms += $urandom_range(0, 20000);
      default: clock_ms += $urandom_range(0, 100);
    endcase
    h.now         = clock_ms;
    h.source      = ($urandom_range(0, 7) != 0) ? src_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                : $urandom;
    h.cls         = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 7)
                                                   : $urandom_range(0, 3));
    h.hops_left   = 3'($urandom_range(0, 7));
    h.hops_origin = 3'($urandom_range(0, 7));
    h.to_us       = ($urandom_range(0, 19) == 0);
    h.from_us     = ($urandom_range(0, 19) == 0);
    h.id_zero     = ($urandom_range(0, 19) == 0);
    h.blocked     = ($urandom_range(0, 19) == 0);
    h.has_flag    = 1'($urandom_range(0, 1));
    h.mqtt_in     = 1'($urandom_range(0, 1));
    return h;
  endfunction

  task automatic test_client_defaults();
    rx_hdr_t h;
    h = base_hdr(CLS_DECODED, MAX_HOPS, 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    h.mqtt_in = 1'b1;
    send_packet(h);
    h = base_hdr(CLS_ENCRYPTED, 3'd1, 3'd0, 32'h0, 32'h0);
    h.has_flag = 1'b1;
    send_packet(h);
  endtask

  task automatic test_drop_reasons();
    rx_hdr_t h;
    // blocked wins over every later reason; output fields must read zero
    h = base_hdr(CLS_TELEMETRY, 3'd0, MAX_HOPS, 32'h1234_5678, 32'd10);
    {h.mqtt_in, h.has_flag, h.blocked, h.id_zero, h.from_us, h.to_us} = 6'b111111;
    send_packet(h);
    h = base_hdr(CLS_POSITION, 3'd4, 3'd4, 32'h1, 32'd20);
    h.to_us = 1'b1;
    send_packet(h);
    h = base_hdr(CLS_POSITION, 3'd0, 3'd4, 32'h1, 32'd30);
    send_packet(h);
    h = base_hdr(CLS_POSITION, 3'd4, 3'd4, 32'h1, 32'd40);
    h.from_us = 1'b1;
    send_packet(h);
    h = base_hdr(CLS_POSITION, 3'd4, 3'd4, 32'h1, 32'd50);
    h.id_zero = 1'b1;
    send_packet(h);
    wait_drained();
    write_reg(REG_NODE_ROLE, {29'd0, ROLE_CLIENT_MUTE});
    send_packet(base_hdr(CLS_NODEINFO, 3'd5, 3'd5, 32'h2, 32'd60));
    wait_drained();
    write_reg(REG_NODE_ROLE, {29'd0, ROLE_SPARE_7});
    send_packet(base_hdr(CLS_NODEINFO, 3'd5, 3'd5, 32'h2, 32'd70));
    wait_drained();
    write_reg(REG_NODE_ROLE, {29'd0, ROLE_ROUTER});
    write_reg(REG_REBCAST_EN, 32'd0);
    send_packet(base_hdr(CLS_ENCRYPTED, 3'd5, 3'd5, 32'h3, 32'd80));
  endtask

  task automatic test_router_hops();
    rx_hdr_t h;
    apply_setting(ROLE_ROUTER, 1'b1, 32'd0, 32'd0);
    send_packet(base_hdr(CLS_ENCRYPTED, 3'd3, 3'd5, 32'h10, 32'd100));
    send_packet(base_hdr(CLS_TELEMETRY, 3'd6, 3'd7, 32'h11, 32'd100));
    send_packet(base_hdr(CLS_POSITION, MAX_HOPS, MAX_HOPS, 32'h12, 32'd100));
    send_packet(base_hdr(CLS_NODEINFO, 3'd2, 3'd2, 32'h13, 32'd100));
    send_packet(base_hdr(CLS_DECODED, MAX_HOPS, MAX_HOPS, 32'h14, 32'd100));
    h = base_hdr(CLS_SPARE_7, 3'd3, MAX_HOPS, 32'h15, 32'd100);
    h.has_flag = 1'b1;
    send_packet(h);
    wait_drained();
    write_reg(REG_NODE_ROLE, {29'd0, ROLE_ROUTER_LATE});
    send_packet(base_hdr(CLS_TELEMETRY, 3'd5, 3'd5, 32'h16, 32'd200));
    send_packet(base_hdr(CLS_TELEMETRY, LATE_TELEM_HOPS, 3'd5, 32'h17, 32'd200));
    wait_drained();
    write_reg(REG_NODE_ROLE, {29'd0, ROLE_REPEATER});
    send_packet(base_hdr(CLS_TELEMETRY, 3'd4, 3'd6, 32'h18, 32'd300));
  endtask

  task automatic test_rate_window();
    apply_setting(ROLE_ROUTER, 1'b1, 32'd0, 32'd100);
    // drop inside the window, refresh once the full window has passed
    send_packet(base_hdr(CLS_POSITION, 3'd3, 3'd3, 32'hA5A5_0001, 32'd1000));
    send_packet(base_hdr(CLS_POSITION, 3'd3, 3'd3, 32'hA5A5_0001, 32'd1050));
    send_packet(base_hdr(CLS_POSITION, 3'd3, 3'd3, 32'hA5A5_0001, 32'd1100));
    // zero timeout never limits
    send_packet(base_hdr(CLS_ENCRYPTED, 3'd2, 3'd3, 32'h5A5A_0002, 32'd5));
    send_packet(base_hdr(CLS_ENCRYPTED, 3'd2, 3'd3, 32'h5A5A_0002, 32'd5));
  endtask

  task automatic test_random_traffic();
    logic [2:0]  role;
    logic        en;
    logic [31:0] enc;
    logic [31:0] dec;
    int          count;
    for (int ph = 0; ph < 12; ph++) begin
      role  = ROLE_ROUTER;
      en    = 1'b1;
      enc   = $urandom_range(2000, 30000);
      dec   = $urandom_range(2000, 30000);
      count = 125;
      case (ph)
        1:  role = ROLE_ROUTER_LATE;
        2:  begin role = ROLE_REPEATER; enc = 32'd0; dec = 32'hFFFF_FFFF; end
        3:  begin enc = 32'hFFFF_FFFF; dec = 32'd0; end
        4:  begin role = ROLE_CLIENT; count = 40; end
        5:  begin role = ROLE_CLIENT_MUTE; count = 40; end
        6:  begin role = ROLE_SPARE_6; count = 40; end
        7:  begin en = 1'b0; count = 40; end
        8:  begin role = ROLE_OTHER; count = 40; end
        9, 10, 11: role = 3'($urandom_range(ROLE_ROUTER, ROLE_REPEATER));
        default: ;
      endcase
      apply_setting(role, en, enc, dec);
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      // a random choice per phase, about half, starts just short of the time wrap
      clock_ms = $urandom_range(0, 1) ? 32'hFFFF_8000 : $urandom;
      foreach (src_pool[i]) src_pool[i] = $urandom;
      repeat (count) send_packet(random_hdr());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_client_defaults();
    test_drop_reasons();
    test_router_hops();
    test_rate_window();
    test_random_traffic();
    wait_drained();
    repeat (TRACK_DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("[mesh_rebroadcast_filter] OK");
    end else begin
      $display("[mesh_rebroadcast_filter] ERROR");
    end
    $finish;
  end

endmodule
